### src/fevd_pkg.sv
// Shared types and constants of the frame energy voice detector.
`default_nettype none
package fevd_pkg;

    localparam int MAX_FRAME_SAMPLES = 1024;
    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 48;
    localparam int SCORE_W  = 16;
    localparam int EVENT_W  = 2;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // The count must hold the frame limit itself; the sum holds a full frame of
    // the largest magnitude.
    localparam int CNT_W  = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int SUM_W  = $clog2(MAX_FRAME_SAMPLES * 32768 + 1);
    localparam int MAG_W  = SAMPLE_W + 1;
    localparam int STEP_W = $clog2(SUM_W);

    // The largest silence window in microseconds fits in this width.
    localparam int LIMIT_W = 26;
    localparam logic [LIMIT_W-1:0] US_PER_MS = LIMIT_W'(1000);

    localparam logic [CNT_W-1:0] FRAME_LIMIT = CNT_W'(MAX_FRAME_SAMPLES);

    localparam logic [EVENT_W-1:0] EV_NONE  = 2'd0;
    localparam logic [EVENT_W-1:0] EV_START = 2'd1;
    localparam logic [EVENT_W-1:0] EV_STOP  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DETECT_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_THRESH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_WINDOW = 2'd2;

    // Finished frame handed from the accumulator to the divider.
    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [CNT_W-1:0]  count;
        logic [TIME_W-1:0] now;
    } frame_req_t;

    // Quotient handed from the divider to the decision stage.
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [TIME_W-1:0]  now;
    } frame_res_t;

endpackage
`default_nettype wire

### src/fevd_if.sv
// Handshake channels for audio items and for frame results.
`default_nettype none
interface fevd_audio_if;
    import fevd_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                frame_end;
    logic [TIME_W-1:0]   time_us;

    modport source (output valid, output sample, output frame_end, output time_us,
                    input ready);
    modport sink (input valid, input sample, input frame_end, input time_us,
                  output ready);
endinterface

interface fevd_result_if;
    import fevd_pkg::*;

    logic               valid;
    logic               ready;
    logic [SCORE_W-1:0] score;
    logic               talking;
    logic [EVENT_W-1:0] event_res;

    modport source (output valid, output score, output talking, output event_res,
                    input ready);
    modport sink (input valid, input score, input talking, input event_res,
                  output ready);
endinterface
`default_nettype wire

### src/fevd_accum.sv
// Frame accumulator: sums sample magnitudes and counts samples up to the frame limit.
`default_nettype none
module fevd_accum (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          take,
    input  wire logic [fevd_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                          frame_end,
    input  wire logic [fevd_pkg::TIME_W-1:0]   time_us,
    output fevd_pkg::frame_req_t               req
);
    import fevd_pkg::*;

    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [MAG_W-1:0] mag;
    logic [SUM_W-1:0] sum_inc;
    logic [CNT_W-1:0] count_inc;
    logic             room;

    always_comb
    begin
        if (sample[SAMPLE_W-1])
        begin
            mag = MAG_W'({1'b0, ~sample}) + MAG_W'(1);
        end
        else
        begin
            mag = {1'b0, sample};
        end
    end

    // Samples past the frame limit are dropped, the closing one included.
    assign room      = (count_reg < FRAME_LIMIT);
    assign sum_inc   = room ? (sum_reg + SUM_W'(mag)) : sum_reg;
    assign count_inc = room ? (count_reg + CNT_W'(1)) : count_reg;

    assign req.sum   = sum_inc;
    assign req.count = count_inc;
    assign req.now   = time_us;

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (take)
        begin
            if (frame_end)
            begin
                sum_next   = '0;
                count_next = '0;
            end
            else
            begin
                sum_next   = sum_inc;
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

### src/fevd_div.sv
// Bit-serial restoring divider: frame sum over sample count, one quotient bit per cycle.
`default_nettype none
module fevd_div (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire fevd_pkg::frame_req_t req,
    output logic                res_valid,
    input  wire logic           res_ready,
    output fevd_pkg::frame_res_t res
);
    import fevd_pkg::*;

    typedef enum logic [2:0] {
        DIV_IDLE = 3'b001,
        DIV_RUN  = 3'b010,
        DIV_DONE = 3'b100
    } div_state_t;

    div_state_t        state_reg, state_next;
    logic [SUM_W-1:0]  work_reg, work_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  divisor_reg, divisor_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    trial_sub;
    logic              fits;

    // The dividend shifts out at the top while quotient bits shift in at the bottom.
    assign trial     = {rem_reg, work_reg[SUM_W-1]};
    assign fits      = (trial >= {1'b0, divisor_reg});
    assign trial_sub = trial - {1'b0, divisor_reg};

    assign req_ready = (state_reg == DIV_IDLE);
    assign res_valid = (state_reg == DIV_DONE);
    assign res.score = work_reg[SCORE_W-1:0];
    assign res.now   = now_reg;

    always_comb
    begin
        state_next   = state_reg;
        work_next    = work_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        step_next    = step_reg;
        now_next     = now_reg;
        case (state_reg)
            DIV_IDLE:
            begin
                if (req_valid)
                begin
                    work_next    = req.sum;
                    rem_next     = '0;
                    divisor_next = req.count;
                    now_next     = req.now;
                    step_next    = STEP_W'(SUM_W - 1);
                    state_next   = DIV_RUN;
                end
            end
            DIV_RUN:
            begin
                work_next = {work_reg[SUM_W-2:0], fits};
                rem_next  = fits ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    state_next = DIV_DONE;
                end
            end
            DIV_DONE:
            begin
                if (res_ready)
                begin
                    state_next = DIV_IDLE;
                end
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg    <= work_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        step_reg    <= step_next;
        now_reg     <= now_next;
    end

endmodule
`default_nettype wire

### src/fevd_decide.sv
// Configuration registers, talk and quiet decision with hangover, and the result register.
`default_nettype none
module fevd_decide (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [fevd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [fevd_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                           res_valid,
    output logic                                res_ready,
    input  wire fevd_pkg::frame_res_t           res,
    fevd_result_if.source                       result
);
    import fevd_pkg::*;

    logic               enable_reg;
    logic [CFG_W-1:0]   thresh_reg;
    logic [CFG_W-1:0]   window_reg;

    logic               talking_reg, talking_next;
    logic [TIME_W-1:0]  quiet_reg, quiet_next;

    // First stage: score, speech flag, elapsed quiet time and window limit.
    logic               s1_valid_reg;
    logic               s1_en_reg;
    logic               s1_speech_reg;
    logic [SCORE_W-1:0] s1_score_reg;
    logic [TIME_W-1:0]  s1_quiet_reg;
    logic [TIME_W-1:0]  s1_elapsed_reg;
    logic [LIMIT_W-1:0] s1_limit_reg;

    logic               out_valid_reg;
    logic [SCORE_W-1:0] out_score_reg;
    logic               out_talking_reg;
    logic [EVENT_W-1:0] out_event_reg;
    logic [EVENT_W-1:0] event_next;

    logic               take;
    logic [TIME_W-1:0]  quiet_eff;
    logic [TIME_W:0]    diff;

    // A result is taken only when both stages ahead are empty, so stage two
    // always finds the result register free.
    assign res_ready = !s1_valid_reg && !out_valid_reg;
    assign take      = res_valid && res_ready;

    // A recorded quiet time of zero means none is set yet.
    assign quiet_eff = (quiet_reg == '0) ? res.now : quiet_reg;
    assign diff      = {1'b0, res.now} - {1'b0, quiet_eff};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            thresh_reg <= '0;
            window_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DETECT_ENABLE:  enable_reg <= cfg_data[0];
                CFG_ENERGY_THRESH:  thresh_reg <= cfg_data;
                CFG_SILENCE_WINDOW: window_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_en_reg      <= enable_reg;
            s1_speech_reg  <= (res.score > thresh_reg);
            s1_score_reg   <= enable_reg ? res.score : '0;
            s1_quiet_reg   <= quiet_eff;
            s1_elapsed_reg <= diff[TIME_W] ? '0 : diff[TIME_W-1:0];
            s1_limit_reg   <= LIMIT_W'(window_reg) * US_PER_MS;
        end
    end

    always_comb
    begin
        talking_next = talking_reg;
        quiet_next   = quiet_reg;
        event_next   = EV_NONE;
        if (s1_en_reg)
        begin
            if (s1_speech_reg)
            begin
                talking_next = 1'b1;
                quiet_next   = '0;
                if (!talking_reg)
                begin
                    event_next = EV_START;
                end
            end
            else
            begin
                quiet_next = s1_quiet_reg;
                if (talking_reg &&
                    (s1_elapsed_reg > {{(TIME_W-LIMIT_W){1'b0}}, s1_limit_reg}))
                begin
                    talking_next = 1'b0;
                    event_next   = EV_STOP;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            talking_reg   <= 1'b0;
            quiet_reg     <= '0;
        end
        else
        begin
            s1_valid_reg <= take;
            if (s1_valid_reg)
            begin
                out_valid_reg <= 1'b1;
                talking_reg   <= talking_next;
                quiet_reg     <= quiet_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            out_score_reg   <= s1_score_reg;
            out_talking_reg <= talking_next;
            out_event_reg   <= event_next;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.score     = out_score_reg;
    assign result.talking   = out_talking_reg;
    assign result.event_res = out_event_reg;

endmodule
`default_nettype wire

### src/frame_energy_voice_detector_core.sv
// Throughput: an item without frame end is taken every cycle; a frame-end item needs the divider
// idle, so a frame cannot close before the last frame's quotient has left; samples keep flowing.
// Path: a frame's result passes through the 26-step bit-serial divider, the first decision stage
// and the result register. A waiting result register holds the divider, so closing items stall.
// Reset: rst_n clears the frame sum and count, the talking state, the quiet time, the
// configuration registers and all valid flags; detection is off after reset.
`default_nettype none
module frame_energy_voice_detector_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [fevd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [fevd_pkg::CFG_W-1:0]     cfg_data,
    fevd_audio_if.sink                          audio,
    fevd_result_if.source                       result
);
    import fevd_pkg::*;

    frame_req_t req;
    frame_res_t res;
    logic       take;
    logic       req_valid;
    logic       req_ready;
    logic       res_valid;
    logic       res_ready;

    // Only the closing item of a frame waits for the divider.
    assign audio.ready = !audio.frame_end || req_ready;
    assign take        = audio.valid && audio.ready;
    assign req_valid   = take && audio.frame_end;

    fevd_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .sample    (audio.sample),
        .frame_end (audio.frame_end),
        .time_us   (audio.time_us),
        .req       (req)
    );

    fevd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    fevd_decide u_decide (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .result    (result)
    );

endmodule
`default_nettype wire
